### design/ascii_integer_parser_assert.svh
// assertion macros shared by the ascii integer parser modules
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// condition holds at every edge out of reset
`define AIP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AIP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/aip_pkg.sv
// shared types, constants and helpers of the ascii integer parser
`timescale 1ns / 1ps
package aip_pkg;

  localparam int MAX_OFFSET_BITS = 16;
  localparam int BASE_W          = 6;
  localparam int VALUE_W         = 64;
  localparam int OFFSET_W        = 16;
  localparam int DIGIT_W         = 6;

  localparam logic [MAX_OFFSET_BITS-1:0] POS_MAX = '1;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

  // parse phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZAUTO  = 3'd3;
  localparam logic [2:0] PH_ZHEX   = 3'd4;
  localparam logic [2:0] PH_DIGITS = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] NO_DIGIT = 8'd255;

  // queue depths
  localparam int OPQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // work passed from the classifier to the accumulator
  typedef struct packed {
    logic                 clear;
    logic                 mac;
    logic                 emit;
    logic                 neg;
    logic [BASE_W-1:0]    base;
    logic [DIGIT_W-1:0]   digit;
    logic [OFFSET_W-1:0]  offset;
  } op_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [OFFSET_W-1:0]       offset;
  } res_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = NO_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end
    return d;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == CH_LX) || (c == CH_UX);
  endfunction

  function automatic logic [OFFSET_W-1:0] to_offset(input logic [MAX_OFFSET_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[OFFSET_W-1:0];
  endfunction

endpackage

### design/ascii_integer_parser.sv
// top level of the streaming ascii to integer parser
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  -------------------------
//  input    in_character, in_first_of_string        in_push & !in_full
//  result   out_parsed_value, out_end_offset        out_pop & !out_empty
//  config   cfg_wr_data (number_base)               cfg_wr_en, no wait
//
// one character word accepted per cycle while in_full is low; a result shows on the
// out_ ports once the terminating character has passed the work queue and the result queue
// the result path is set by the 64 x 6 multiply-add in the accumulator stage
// synchronous active-low reset; no clearing pass, words accepted right away
// a stalled result side fills the two-entry result queue, then the two-entry
// work queue, and only then raises in_full
`timescale 1ns / 1ps
module ascii_integer_parser import aip_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic [7:0]                in_character,
  input  logic                      in_first_of_string,
  input  logic                      in_push,
  output logic                      in_full,
  // result channel
  output logic signed [VALUE_W-1:0] out_parsed_value,
  output logic [OFFSET_W-1:0]       out_end_offset,
  output logic                      out_empty,
  input  logic                      out_pop,
  // base register
  input  logic                      cfg_wr_en,
  input  logic [BASE_W-1:0]         cfg_wr_data
);

  logic in_accept;
  logic op_push, op_valid, op_pop;
  op_t  op_front, op_head;

  // the full flag of the work queue guards the input side
  assign in_accept = in_push && !in_full;

  // classifier: whitespace, sign, prefix and digit decisions, offset count
  aip_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept_i    (in_accept),
    .char_i      (in_character),
    .first_i     (in_first_of_string),
    .op_push_o   (op_push),
    .op_o        (op_front)
  );

  // decouples the classifier from the accumulator stalls
  aip_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (op_push),
    .op_i    (op_front),
    .full_o  (in_full),
    .valid_o (op_valid),
    .op_o    (op_head),
    .pop_i   (op_pop)
  );

  // accumulator and result queue
  aip_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid_i       (op_valid),
    .op_i             (op_head),
    .op_pop_o         (op_pop),
    .out_parsed_value (out_parsed_value),
    .out_end_offset   (out_end_offset),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

endmodule

### design/aip_front.sv
// front end: base register, parse phase tracking and character classification
`timescale 1ns / 1ps
`include "ascii_integer_parser_assert.svh"
module aip_front import aip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data,
  input  logic              accept_i,
  input  logic [7:0]        char_i,
  input  logic              first_i,
  output logic              op_push_o,
  output op_t               op_o
);

  logic [BASE_W-1:0]          cfg_base_r;
  logic [2:0]                 phase_r, phase_nxt;
  logic [BASE_W-1:0]          base_r, base_nxt;
  logic                       neg_r, neg_nxt;
  logic [MAX_OFFSET_BITS-1:0] pos_r, pos_nxt;

  logic [2:0]                 ph;
  logic [BASE_W-1:0]          base_in;
  logic                       neg_in;
  logic [MAX_OFFSET_BITS-1:0] pos_in;
  logic                       go_prefix, go_digits, bump, do_mac, do_emit;
  logic [7:0]                 dval;

  always_comb begin
    ph      = first_i ? PH_START : phase_r;
    base_in = first_i ? cfg_base_r : base_r;
    neg_in  = first_i ? 1'b0 : neg_r;
    pos_in  = first_i ? '0 : pos_r;
    dval    = digit_value(char_i);

    phase_nxt = ph;
    base_nxt  = base_in;
    neg_nxt   = neg_in;
    go_prefix = 1'b0;
    go_digits = 1'b0;
    bump      = 1'b0;
    do_mac    = 1'b0;
    do_emit   = 1'b0;

    unique case (ph)
      PH_IDLE: begin
      end
      PH_START: begin
        if (is_blank(char_i)) begin
          bump = 1'b1;
        end else begin
          phase_nxt = PH_PREFIX;
          if (char_i == CH_MINUS || char_i == CH_PLUS) begin
            neg_nxt = (char_i == CH_MINUS);
            bump    = 1'b1;
          end else begin
            go_prefix = 1'b1;
          end
        end
      end
      PH_PREFIX: go_prefix = 1'b1;
      PH_ZAUTO: begin
        phase_nxt = PH_DIGITS;
        if (is_x(char_i)) begin
          base_nxt = BASE_HEX;
          bump     = 1'b1;
        end else begin
          base_nxt  = BASE_OCT;
          go_digits = 1'b1;
        end
      end
      PH_ZHEX: begin
        // a lone zero before a non-x is just a zero digit, value stays zero
        phase_nxt = PH_DIGITS;
        if (is_x(char_i)) begin
          bump = 1'b1;
        end else begin
          go_digits = 1'b1;
        end
      end
      PH_DIGITS: go_digits = 1'b1;
      default: phase_nxt = PH_IDLE;
    endcase

    if (go_prefix) begin
      if (base_in == BASE_AUTO) begin
        if (char_i == CH_0) begin
          bump      = 1'b1;
          phase_nxt = PH_ZAUTO;
        end else begin
          base_nxt  = BASE_DEC;
          phase_nxt = PH_DIGITS;
          go_digits = 1'b1;
        end
      end else if (base_in == BASE_HEX && char_i == CH_0) begin
        bump      = 1'b1;
        phase_nxt = PH_ZHEX;
      end else begin
        phase_nxt = PH_DIGITS;
        go_digits = 1'b1;
      end
    end

    if (go_digits) begin
      if (dval < 8'(base_nxt)) begin
        do_mac = 1'b1;
        bump   = 1'b1;
      end else begin
        do_emit   = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end

    pos_nxt = (bump && pos_in != POS_MAX) ? pos_in + 1'b1 : pos_in;
  end

  assign op_o.clear  = first_i;
  assign op_o.mac    = do_mac;
  assign op_o.emit   = do_emit;
  assign op_o.neg    = neg_nxt;
  assign op_o.base   = base_nxt;
  assign op_o.digit  = dval[DIGIT_W-1:0];
  assign op_o.offset = to_offset(pos_in);
  assign op_push_o   = accept_i && (first_i || do_mac || do_emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= BASE_RESET;
      phase_r    <= PH_IDLE;
      base_r     <= '0;
      neg_r      <= 1'b0;
      pos_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_base_r <= cfg_wr_data;
      end
      if (accept_i) begin
        phase_r <= phase_nxt;
        base_r  <= base_nxt;
        neg_r   <= neg_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

  `AIP_ASSERT_NEXT(a_emit_ends, accept_i && do_emit, phase_r == PH_IDLE, "emit did not end parse")
  `AIP_ASSERT_SAME(a_idle_quiet, accept_i && !first_i && phase_r == PH_IDLE, !op_push_o, "idle word made work")

endmodule

### design/aip_opq.sv
// two-entry queue of work between the front end and the accumulator
`timescale 1ns / 1ps
`include "ascii_integer_parser_assert.svh"
module aip_opq import aip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  output logic valid_o,
  output op_t  op_o,
  input  logic pop_i
);

  localparam int PTR_W = $clog2(OPQ_DEPTH);
  localparam int CNT_W = $clog2(OPQ_DEPTH + 1);

  op_t              mem_r [OPQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == CNT_W'(OPQ_DEPTH));
  assign valid_o = (cnt_r != '0);
  assign op_o    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= op_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  `AIP_ASSERT_ALWAYS(a_opq_bound, cnt_r <= CNT_W'(OPQ_DEPTH), "op queue overfilled")
  `AIP_ASSERT_SAME(a_opq_nopush_full, full_o, !push_i, "push into full op queue")

endmodule

### design/aip_back.sv
// back end: 64-bit multiply-accumulate, sign and two-entry result queue
`timescale 1ns / 1ps
`include "ascii_integer_parser_assert.svh"
module aip_back import aip_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid_i,
  input  op_t                        op_i,
  output logic                       op_pop_o,
  output logic signed [VALUE_W-1:0]  out_parsed_value,
  output logic [OFFSET_W-1:0]        out_end_offset,
  output logic                       out_empty,
  input  logic                       out_pop
);

  localparam int PTR_W = $clog2(RESQ_DEPTH);
  localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

  logic [VALUE_W-1:0] acc_r, acc_nxt, acc_src, prod;
  res_t               res_q_r [RESQ_DEPTH];
  res_t               res_new;
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               res_full, res_push, res_pop;

  assign res_full = (cnt_r == CNT_W'(RESQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign res_pop   = out_pop && !out_empty;

  // emit waits for a free result slot, other work never stalls
  assign op_pop_o = op_valid_i && (!op_i.emit || !res_full);
  assign res_push = op_pop_o && op_i.emit;

  assign acc_src = op_i.clear ? '0 : acc_r;
  assign prod    = acc_src * VALUE_W'(op_i.base);

  always_comb begin
    acc_nxt = acc_src;
    if (op_i.mac) begin
      acc_nxt = prod + VALUE_W'(op_i.digit);
    end
  end

  assign res_new.value  = op_i.neg ? -acc_src : acc_src;
  assign res_new.offset = op_i.offset;

  assign out_parsed_value = res_q_r[rd_ptr_r].value;
  assign out_end_offset   = res_q_r[rd_ptr_r].offset;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !res_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (res_pop && !res_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop_o) begin
      acc_r <= acc_nxt;
    end
    if (res_push) begin
      res_q_r[wr_ptr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (res_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  `AIP_ASSERT_ALWAYS(a_res_bound, cnt_r <= CNT_W'(RESQ_DEPTH), "result queue overfilled")
  `AIP_ASSERT_NEXT(a_emit_lands, res_push, !out_empty, "emitted word not visible")

endmodule

### dv/ascii_integer_parser_test.sv
// self-checking testbench of the ascii integer parser, directed and random strings
`timescale 1ns / 1ps
module ascii_integer_parser_test;
  import aip_pkg::*;

  // conversion phases of the predictor
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_START,
    SCAN_BASE_PICK,
    SCAN_AUTO_ZERO,
    SCAN_HEX_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  localparam logic [7:0] CH_NUL        = 8'd0;
  localparam logic [7:0] CH_BACKSPACE  = 8'd8;
  localparam logic [7:0] CH_SHIFT_OUT  = 8'd14;
  localparam logic [7:0] CH_TOP        = 8'd255;
  localparam logic [5:0] BASE_UNARY    = 6'd1;
  localparam logic [5:0] BASE_BINARY   = 6'd2;
  localparam logic [5:0] BASE_ALNUM    = 6'd36;
  localparam logic [5:0] BASE_TOP      = 6'd63;
  localparam int         SETTLE_CYCLES = 8;

  logic                      clk                = 1'b0;
  logic                      rst_n              = 1'b0;
  logic [7:0]                in_character       = '0;
  logic                      in_first_of_string = 1'b0;
  logic                      in_push            = 1'b0;
  logic                      in_full;
  logic signed [VALUE_W-1:0] out_parsed_value;
  logic [OFFSET_W-1:0]       out_end_offset;
  logic                      out_empty;
  logic                      out_pop            = 1'b0;
  logic                      cfg_wr_en          = 1'b0;
  logic [BASE_W-1:0]         cfg_wr_data        = '0;

  // predictor state, a copy of what the parser keeps per string
  logic [BASE_W-1:0]   radix_setting;
  scan_phase_t         scan_phase;
  bit                  minus_seen;
  logic [VALUE_W-1:0]  running_value;
  logic [BASE_W-1:0]   radix_in_use;
  logic [OFFSET_W-1:0] chars_consumed;

  res_t expected_numbers[$];
  int   mismatch_count = 0;
  bit   sender_idles   = 1'b0;
  bit   sink_idles     = 1'b0;
  bit   idling_allowed = 1'b1;
  int   sink_hold      = 0;

  ascii_integer_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_character       (in_character),
    .in_first_of_string (in_first_of_string),
    .in_push            (in_push),
    .in_full            (in_full),
    .out_parsed_value   (out_parsed_value),
    .out_end_offset     (out_end_offset),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // generous ceiling, far above the slowest legal run
  initial begin
    #200_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic void count_char();
    // position counter sticks at all ones
    if (chars_consumed != '1) begin
      chars_consumed++;
    end
  endfunction

  // advances the predictor by one character word; returns 1 when the word ends a number
  function automatic bit convert_char(input logic [7:0] ch, input logic first,
                                      output res_t number);
    logic [7:0] digit;
    int         guard;
    number = '0;
    if (first) begin
      scan_phase     = SCAN_START;
      minus_seen     = 1'b0;
      running_value  = '0;
      radix_in_use   = radix_setting;
      chars_consumed = '0;
    end
    if (scan_phase == SCAN_IDLE) begin
      return 1'b0;
    end
    // a word may fall through several phases before it is consumed
    for (guard = 0; guard < 8; guard++) begin
      case (scan_phase)
        SCAN_START: begin
          if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            count_char();
            return 1'b0;
          end
          scan_phase = SCAN_BASE_PICK;
          if (ch == CH_MINUS || ch == CH_PLUS) begin
            minus_seen = (ch == CH_MINUS);
            count_char();
            return 1'b0;
          end
        end
        SCAN_BASE_PICK: begin
          if (radix_in_use == BASE_AUTO) begin
            if (ch == CH_0) begin
              count_char();
              scan_phase = SCAN_AUTO_ZERO;
              return 1'b0;
            end
            radix_in_use = BASE_DEC;
            scan_phase   = SCAN_DIGITS;
          end else if (radix_in_use == BASE_HEX && ch == CH_0) begin
            count_char();
            scan_phase = SCAN_HEX_ZERO;
            return 1'b0;
          end else begin
            scan_phase = SCAN_DIGITS;
          end
        end
        SCAN_AUTO_ZERO: begin
          scan_phase = SCAN_DIGITS;
          if (ch == CH_LX || ch == CH_UX) begin
            radix_in_use = BASE_HEX;
            count_char();
            return 1'b0;
          end
          radix_in_use = BASE_OCT;
        end
        SCAN_HEX_ZERO: begin
          // either the prefix follows, or the zero was a plain digit
          scan_phase = SCAN_DIGITS;
          if (ch == CH_LX || ch == CH_UX) begin
            count_char();
            return 1'b0;
          end
          running_value = running_value * 64'd16;
        end
        SCAN_DIGITS: begin
          if (ch >= CH_0 && ch <= CH_9) begin
            digit = ch - CH_0;
          end else if (ch >= CH_UA && ch <= CH_UZ) begin
            digit = ch - CH_UA + 8'd10;
          end else if (ch >= CH_LA && ch <= CH_LZ) begin
            digit = ch - CH_LA + 8'd10;
          end else begin
            digit = 8'd255;
          end
          if (ch != CH_NUL && digit < {2'b00, radix_in_use}) begin
            running_value = running_value * 64'(radix_in_use) + 64'(digit);
            count_char();
            return 1'b0;
          end
          number.value  = minus_seen ? (64'd0 - running_value) : running_value;
          number.offset = chars_consumed;
          scan_phase    = SCAN_IDLE;
          return 1'b1;
        end
        default: begin
          scan_phase = SCAN_IDLE;
          return 1'b0;
        end
      endcase
    end
    return 1'b0;
  endfunction

  // result side: random pop stalls, every accepted word checked against the oldest number
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      out_pop <= 1'b0;
    end else if (sink_idles && $urandom_range(0, 7) == 0) begin
      sink_hold = $urandom_range(1, 19) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d offset %0d",
                                  out_parsed_value, out_end_offset));
      end else begin
        want = expected_numbers.pop_front();
        if (out_parsed_value !== want.value) begin
          report_mismatch($sformatf("value %0d, wanted %0d", out_parsed_value, want.value));
        end
        if (out_end_offset !== want.offset) begin
          report_mismatch($sformatf("offset %0d, wanted %0d", out_end_offset, want.offset));
        end
      end
    end
  end

  // one character word; in_push stays high on return so back-to-back words flow
  task automatic send_char(input logic [7:0] ch, input logic first);
    res_t number;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_push            <= 1'b1;
    in_character       <= ch;
    in_first_of_string <= first;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (convert_char(ch, first, number)) begin
      expected_numbers.push_back(number);
    end
  endtask

  task automatic send_text(input string text, input bit start);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], start && i == 0);
    end
  endtask

  // sender holds off until every number is back, then lets silent words drain
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_numbers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // meant to be called with the parser idle, which the task itself does not check
  task automatic write_base(input logic [BASE_W-1:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    radix_setting  = base;
  endtask

  task automatic test_signs_and_blanks();
    drain_results();
    write_base(BASE_DEC);
    send_text(" -12", 1'b1);
    send_char(CH_TOP, 1'b0);
    send_text("+7", 1'b1);
    send_char(CH_NUL, 1'b0);
    // stray word with no string open
    send_char(CH_LZ, 1'b0);
    // whitespace edges, sign but no digits
    send_text("\t\r-", 1'b1);
    send_char(CH_NUL, 1'b0);
    // just outside the whitespace range
    send_char(CH_BACKSPACE, 1'b1);
    send_char(CH_SHIFT_OUT, 1'b1);
    // restart drops the open string without a result
    send_text("9", 1'b1);
    send_text("5", 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_auto_base();
    drain_results();
    write_base(BASE_AUTO);
    send_text("0x1f", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("017", 1'b1);
    send_char(CH_NUL, 1'b0);
    // bare hex prefix is still consumed
    send_text("0xg", 1'b1);
    send_text("0", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("-0X", 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_hex_base();
    drain_results();
    write_base(BASE_HEX);
    send_text("0XfF", 1'b1);
    send_char(CH_NUL, 1'b0);
    // the zero turns out to be a digit
    send_text("08", 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_narrow_and_wide_bases();
    drain_results();
    write_base(BASE_UNARY);
    send_text("001", 1'b1);
    drain_results();
    write_base(BASE_TOP);
    send_text("zZ9", 1'b1);
    send_char(CH_NUL, 1'b0);
    drain_results();
    write_base(BASE_ALNUM);
    send_text("Zz", 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  // a new base only counts from the next first flag
  task automatic test_base_change_mid_string();
    drain_results();
    write_base(BASE_DEC);
    send_text("1", 1'b1);
    drain_results();
    write_base(BASE_BINARY);
    send_text("1", 1'b0);
    send_char(CH_NUL, 1'b0);
    send_text("1012", 1'b1);
  endtask

  task automatic test_extreme_values();
    drain_results();
    write_base(BASE_DEC);
    send_text("-9223372036854775808", 1'b1);
    send_char(CH_NUL, 1'b0);
    send_text("18446744073709551615", 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_random_strings(input int target);
    logic [7:0]        text[$];
    logic [BASE_W-1:0] base;
    int                sent, prefix, ending, radix, value;
    sent = 0;
    while (sent < target) begin
      // now and then a new base, with fresh idling on each side
      if ($urandom_range(0, 14) == 0) begin
        drain_results();
        sender_idles = idling_allowed && $urandom_range(0, 2) != 0;
        sink_idles   = idling_allowed && $urandom_range(0, 2) != 0;
        case ($urandom_range(0, 9))
          0: base = BASE_AUTO;
          1: base = BASE_UNARY;
          2: base = BASE_BINARY;
          3: base = BASE_OCT;
          4: base = BASE_DEC;
          5: base = BASE_HEX;
          6: base = BASE_ALNUM;
          7: base = BASE_TOP;
          default: base = BASE_W'($urandom_range(0, 63));
        endcase
        write_base(base);
      end
      // noise: random bytes, sometimes opening a string
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
      end
      text.delete();
      repeat ($urandom_range(0, 2)) begin
        value = $urandom_range(0, 5);
        text.push_back(value < 5 ? CH_TAB + 8'(value) : CH_SPACE);
      end
      case ($urandom_range(0, 2))
        1: text.push_back(CH_PLUS);
        2: text.push_back(CH_MINUS);
        default: ;
      endcase
      if (radix_setting == BASE_AUTO || radix_setting == BASE_HEX) begin
        prefix = $urandom_range(0, 3);
      end else begin
        prefix = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
      end
      if (prefix != 0) text.push_back(CH_0);
      if (prefix == 2) text.push_back(CH_LX);
      if (prefix == 3) text.push_back(CH_UX);
      // digits mostly valid for the base that will be in force
      radix = int'(radix_setting);
      if (radix == 0) radix = (prefix >= 2) ? 16 : (prefix == 1) ? 8 : 10;
      if (radix > 36) radix = 36;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(13, 25) : $urandom_range(0, 12)) begin
        if ($urandom_range(0, 11) == 0) begin
          text.push_back(8'($urandom_range(0, 255)));
        end else begin
          value = $urandom_range(0, radix - 1);
          if (value < 10) begin
            text.push_back(CH_0 + 8'(value));
          end else begin
            text.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(value - 10));
          end
        end
      end
      // nul, a random byte, or nothing so the next string cuts in
      ending = $urandom_range(0, 3);
      if (ending <= 1) text.push_back(CH_NUL);
      if (ending == 2) text.push_back(8'($urandom_range(0, 255)));
      if (text.size() == 0) text.push_back(CH_NUL);
      foreach (text[i]) send_char(text[i], i == 0);
      sent += text.size();
      // trailing bytes after the end are ignored
      if (ending != 3) begin
        repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  initial begin
    int wait_cycles;
    // predictor starts from the reset state
    radix_setting  = BASE_RESET;
    scan_phase     = SCAN_IDLE;
    minus_seen     = 1'b0;
    running_value  = '0;
    radix_in_use   = '0;
    chars_consumed = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_signs_and_blanks();
    test_auto_base();
    test_hex_base();
    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    test_narrow_and_wide_bases();
    test_base_change_mid_string();
    test_extreme_values();
    test_random_strings(850);

    // closing stretch runs flat out on both sides
    drain_results();
    idling_allowed = 1'b0;
    sender_idles   = 1'b0;
    sink_idles     = 1'b0;
    test_random_strings(150);

    in_push <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 2000 && expected_numbers.size() != 0; wait_cycles++) begin
      @(posedge clk);
    end
    if (expected_numbers.size() != 0) begin
      report_mismatch($sformatf("%0d numbers never came out", expected_numbers.size()));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
